@@ rtl/ssqt_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and control types of the sorted sleep queue timer.
// Used by ssqt_ctrl, ssqt_dp, sorted_sleep_queue_timer and ssqt_checker.
package ssqt_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int TICK_W = 64;
   localparam int SPAN_W = 32;
   localparam int ELAPSED_W = 32;
   localparam int ID_W = 8;
   localparam int KIND_W = 2;
   localparam int MS_W = 10;
   localparam int PROD_W = SPAN_W + MS_W;

   localparam logic [MS_W-1:0] MS_TO_US = MS_W'(1000);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

   typedef enum logic [KIND_W-1:0] {
      KIND_WOKEN  = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WAKE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_TICK,
      ST_CHECK,
      ST_SCAN,
      ST_EMIT_SLEEP,
      ST_EMIT_REL,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic calc_wake;
      logic rd_en;
      logic rd_down;
      logic ins_shift;
      logic ins_put;
      logic tick_add;
      logic scan_step;
      logic scan_done;
      logic emit_sleep;
      logic emit_rel;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic act;
      logic full;
      logic count_zero;
      logic idx_zero;
      logic idx_one;
      logic rd_ge;
      logic rd_le;
      logic scan_end;
      logic rel_go;
      logic rel_flag;
      logic rel_zero;
      logic emit_last;
   } status_type;

endpackage

@@ rtl/sorted_sleep_queue_timer.sv @@
`timescale 1ns / 1ps
// Top level of the sorted sleep queue timer: controller plus datapath.
// Depends on ssqt_pkg, ssqt_ctrl and ssqt_dp.
//
// A beat is accepted when start is high and busy is low. A sleep beat inserts a
// thread into a wake-tick sorted queue of QUEUE_DEPTH entries; every beat then
// advances the 64-bit microsecond tick and releases expired entries. Results
// leave as single-cycle beats marked by rsp_valid, with rsp_last on the final
// one of a step; the receiver cannot stall them, and they form one unbroken run.
// A sleep beat that finds the queue full is rejected. The insertion walk moves
// one entry per cycle from the tail, reading one queue entry and writing another
// in the same cycle, the release walk reads one entry per cycle from the head to
// find the new earliest wake, and the released entries are then read again and
// sent at one per cycle. Results leave from a register, in the cycle after they
// are formed.
module sorted_sleep_queue_timer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_action,
   input  logic [ssqt_pkg::ELAPSED_W-1:0]     req_elapsed_us,
   input  logic [ssqt_pkg::ID_W-1:0]          req_thread_id,
   input  logic [ssqt_pkg::SPAN_W-1:0]        req_sleep_ms,
   output logic                               rsp_valid,
   output logic [ssqt_pkg::KIND_W-1:0]        rsp_kind,
   output logic [ssqt_pkg::ID_W-1:0]          rsp_woken_id,
   output logic [ssqt_pkg::TICK_W-1:0]        rsp_wake_tick,
   output logic [ssqt_pkg::TICK_W-1:0]        rsp_next_wake,
   output logic                               rsp_last
);

   ssqt_pkg::cmd_type    cmd;
   ssqt_pkg::status_type status;

   ssqt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   ssqt_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req_action),
      .req_elapsed_us (req_elapsed_us),
      .req_thread_id  (req_thread_id),
      .req_sleep_ms   (req_sleep_ms),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_woken_id   (rsp_woken_id),
      .rsp_wake_tick  (rsp_wake_tick),
      .rsp_next_wake  (rsp_next_wake),
      .rsp_last       (rsp_last)
   );

endmodule

@@ rtl/ssqt_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine of the sorted sleep queue timer.
// Depends on ssqt_pkg; drives ssqt_dp through command and status structs.
module ssqt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output ssqt_pkg::cmd_type    cmd,
   input  ssqt_pkg::status_type status
);

   ssqt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssqt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         ssqt_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ssqt_pkg::ST_WAKE;
            end
         end
         ssqt_pkg::ST_WAKE: begin
            cmd.calc_wake = 1'b1;
            if (status.act && !status.full) begin
               state_in = status.count_zero ? ssqt_pkg::ST_INS_PUT : ssqt_pkg::ST_INS_RD;
            end else begin
               state_in = ssqt_pkg::ST_TICK;
            end
         end
         ssqt_pkg::ST_INS_RD: begin
            cmd.rd_en = 1'b1;
            cmd.rd_down = 1'b1;
            state_in = ssqt_pkg::ST_INS_CMP;
         end
         ssqt_pkg::ST_INS_CMP: begin
            if (status.rd_ge) begin
               cmd.ins_shift = 1'b1;
               if (status.idx_one) begin
                  state_in = ssqt_pkg::ST_INS_PUT;
               end else begin
                  cmd.rd_en = 1'b1;
                  cmd.rd_down = 1'b1;
               end
            end else begin
               cmd.ins_put = 1'b1;
               state_in = ssqt_pkg::ST_TICK;
            end
         end
         ssqt_pkg::ST_INS_PUT: begin
            cmd.ins_put = 1'b1;
            state_in = ssqt_pkg::ST_TICK;
         end
         ssqt_pkg::ST_TICK: begin
            cmd.tick_add = 1'b1;
            cmd.rd_en = 1'b1;
            state_in = ssqt_pkg::ST_CHECK;
         end
         ssqt_pkg::ST_CHECK: begin
            if (status.rel_go) begin
               state_in = ssqt_pkg::ST_SCAN;
            end else if (status.act) begin
               state_in = ssqt_pkg::ST_EMIT_SLEEP;
            end else begin
               state_in = ssqt_pkg::ST_IDLE;
            end
         end
         ssqt_pkg::ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (status.scan_end || !status.rd_le) begin
               cmd.scan_done = 1'b1;
               if (status.act) begin
                  state_in = ssqt_pkg::ST_EMIT_SLEEP;
               end else if (status.idx_zero) begin
                  state_in = ssqt_pkg::ST_COMMIT;
               end else begin
                  state_in = ssqt_pkg::ST_EMIT_REL;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ssqt_pkg::ST_EMIT_SLEEP: begin
            cmd.emit_sleep = 1'b1;
            if (!status.rel_flag) begin
               state_in = ssqt_pkg::ST_IDLE;
            end else if (status.rel_zero) begin
               state_in = ssqt_pkg::ST_COMMIT;
            end else begin
               state_in = ssqt_pkg::ST_EMIT_REL;
            end
         end
         ssqt_pkg::ST_EMIT_REL: begin
            cmd.emit_rel = 1'b1;
            cmd.rd_en = 1'b1;
            if (status.emit_last) begin
               state_in = ssqt_pkg::ST_COMMIT;
            end
         end
         ssqt_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = ssqt_pkg::ST_IDLE;
         end
         default: begin
            state_in = ssqt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/ssqt_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the sorted sleep queue timer: tick counter, circular queue memory,
// insertion and release walks, and the result register. Depends on ssqt_pkg.
module ssqt_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  ssqt_pkg::cmd_type                  cmd,
   output ssqt_pkg::status_type               status,
   input  logic                               req_action,
   input  logic [ssqt_pkg::ELAPSED_W-1:0]     req_elapsed_us,
   input  logic [ssqt_pkg::ID_W-1:0]          req_thread_id,
   input  logic [ssqt_pkg::SPAN_W-1:0]        req_sleep_ms,
   output logic                               rsp_valid,
   output logic [ssqt_pkg::KIND_W-1:0]        rsp_kind,
   output logic [ssqt_pkg::ID_W-1:0]          rsp_woken_id,
   output logic [ssqt_pkg::TICK_W-1:0]        rsp_wake_tick,
   output logic [ssqt_pkg::TICK_W-1:0]        rsp_next_wake,
   output logic                               rsp_last
);

   // Maps a position counted from the queue head onto a memory address.
   function automatic logic [ssqt_pkg::PTR_W-1:0] to_phys(
      input logic [ssqt_pkg::PTR_W-1:0] head,
      input logic [ssqt_pkg::CNT_W-1:0] ofs
   );
      logic [ssqt_pkg::SUM_W-1:0] sum;
      sum = ssqt_pkg::SUM_W'(head) + ssqt_pkg::SUM_W'(ofs);
      if (sum >= ssqt_pkg::DEPTH_SUM) begin
         sum = sum - ssqt_pkg::DEPTH_SUM;
      end
      return sum[ssqt_pkg::PTR_W-1:0];
   endfunction

   logic [ssqt_pkg::TICK_W-1:0]    queue_wake_ff [ssqt_pkg::QUEUE_DEPTH];
   logic [ssqt_pkg::ID_W-1:0]      queue_id_ff   [ssqt_pkg::QUEUE_DEPTH];

   logic [ssqt_pkg::TICK_W-1:0]    tick_ff, ew_ff, new_ew_ff, wake_ff, rd_wake_ff;
   logic [ssqt_pkg::ID_W-1:0]      id_ff, rd_id_ff;
   logic [ssqt_pkg::SPAN_W-1:0]    span_ff;
   logic [ssqt_pkg::ELAPSED_W-1:0] elapsed_ff;
   logic                           act_ff, rej_ff, rel_flag_ff;
   logic [ssqt_pkg::CNT_W-1:0]     count_ff, idx_ff, idx_in, rel_ff, rd_ofs;
   logic [ssqt_pkg::PTR_W-1:0]     head_ff, rd_addr, wr_addr;
   logic [ssqt_pkg::PROD_W-1:0]    span_prod;
   logic                           wr_en;
   logic [ssqt_pkg::TICK_W-1:0]    wr_wake;
   logic [ssqt_pkg::ID_W-1:0]      wr_id;

   logic                           rsp_valid_ff;
   ssqt_pkg::kind_type             rsp_kind_ff;
   logic [ssqt_pkg::ID_W-1:0]      rsp_id_ff;
   logic [ssqt_pkg::TICK_W-1:0]    rsp_wake_ff, rsp_next_ff;
   logic                           rsp_last_ff;

   assign span_prod = ssqt_pkg::PROD_W'(req_sleep_ms) * ssqt_pkg::PROD_W'(ssqt_pkg::MS_TO_US);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.calc_wake) begin
         idx_in = count_ff;
      end else if (cmd.ins_shift) begin
         idx_in = idx_ff - ssqt_pkg::CNT_ONE;
      end else if (cmd.tick_add || cmd.scan_done) begin
         idx_in = '0;
      end else if (cmd.scan_step || cmd.emit_rel) begin
         idx_in = idx_ff + ssqt_pkg::CNT_ONE;
      end
   end

   assign rd_ofs  = cmd.rd_down ? (idx_in - ssqt_pkg::CNT_ONE) : idx_in;
   assign rd_addr = to_phys(head_ff, rd_ofs);
   assign wr_addr = to_phys(head_ff, idx_ff);
   assign wr_en   = cmd.ins_shift || cmd.ins_put;
   assign wr_wake = cmd.ins_shift ? rd_wake_ff : wake_ff;
   assign wr_id   = cmd.ins_shift ? rd_id_ff : id_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_wake_ff[wr_addr] <= wr_wake;
         queue_id_ff[wr_addr]   <= wr_id;
      end
      if (cmd.rd_en) begin
         rd_wake_ff <= queue_wake_ff[rd_addr];
         rd_id_ff   <= queue_id_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         ew_ff       <= '0;
         count_ff    <= '0;
         head_ff     <= '0;
         idx_ff      <= '0;
         act_ff      <= 1'b0;
         rej_ff      <= 1'b0;
         rel_flag_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (cmd.load) begin
            act_ff      <= req_action;
            rel_flag_ff <= 1'b0;
         end
         if (cmd.calc_wake) begin
            rej_ff <= (count_ff == ssqt_pkg::DEPTH_CNT);
         end
         if (cmd.ins_put) begin
            count_ff <= count_ff + ssqt_pkg::CNT_ONE;
            if ((wake_ff < ew_ff) || (ew_ff == '0)) begin
               ew_ff <= wake_ff;
            end
         end
         if (cmd.tick_add) begin
            tick_ff <= tick_ff + ssqt_pkg::TICK_W'(elapsed_ff);
         end
         if (cmd.scan_done) begin
            rel_flag_ff <= 1'b1;
         end
         if (cmd.commit) begin
            count_ff <= count_ff - rel_ff;
            head_ff  <= to_phys(head_ff, rel_ff);
            ew_ff    <= new_ew_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         elapsed_ff <= req_elapsed_us;
         id_ff      <= req_thread_id;
         span_ff    <= span_prod[ssqt_pkg::SPAN_W-1:0];
      end
      if (cmd.calc_wake) begin
         wake_ff <= tick_ff + ssqt_pkg::TICK_W'(span_ff);
      end
      if (cmd.scan_done) begin
         rel_ff    <= idx_ff;
         new_ew_ff <= status.scan_end ? '0 : rd_wake_ff;
      end
   end

   always_comb begin
      status.act        = act_ff;
      status.full       = (count_ff == ssqt_pkg::DEPTH_CNT);
      status.count_zero = (count_ff == '0);
      status.idx_zero   = (idx_ff == '0);
      status.idx_one    = (idx_ff == ssqt_pkg::CNT_ONE);
      status.rd_ge      = (rd_wake_ff >= wake_ff);
      status.rd_le      = (rd_wake_ff <= tick_ff);
      status.scan_end   = (idx_ff == count_ff);
      status.rel_go     = (tick_ff > ew_ff) && (ew_ff != '0);
      status.rel_flag   = rel_flag_ff;
      status.rel_zero   = (rel_ff == '0);
      status.emit_last  = ((idx_ff + ssqt_pkg::CNT_ONE) == rel_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_sleep || cmd.emit_rel;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_sleep) begin
         rsp_kind_ff <= rej_ff ? ssqt_pkg::KIND_REJECT : ssqt_pkg::KIND_ACCEPT;
         rsp_id_ff   <= id_ff;
         rsp_wake_ff <= wake_ff;
         rsp_next_ff <= rel_flag_ff ? new_ew_ff : ew_ff;
         rsp_last_ff <= !(rel_flag_ff && (rel_ff != '0));
      end else if (cmd.emit_rel) begin
         rsp_kind_ff <= ssqt_pkg::KIND_WOKEN;
         rsp_id_ff   <= rd_id_ff;
         rsp_wake_ff <= rd_wake_ff;
         rsp_next_ff <= new_ew_ff;
         rsp_last_ff <= status.emit_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_woken_id  = rsp_id_ff;
   assign rsp_wake_tick = rsp_wake_ff;
   assign rsp_next_wake = rsp_next_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

@@ rtl/ssqt_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker of the sorted sleep queue timer, bound to the top level.
// Depends on ssqt_pkg and sorted_sleep_queue_timer.
module ssqt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [ssqt_pkg::KIND_W-1:0]     rsp_kind,
   input logic [ssqt_pkg::TICK_W-1:0]     rsp_next_wake,
   input logic                            rsp_last
);

   // An accepted beat holds the block busy, with no result in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted beat did not start a busy step");

   // The results of one step arrive without gaps.
   a_run_unbroken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("result run broken before its last beat");

   // Only the first result of a step can be a sleep result.
   a_woken_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> (rsp_kind == ssqt_pkg::KIND_WOKEN))
      else $error("sleep result inside a run");

   // Every result of one step reports the same next wake tick.
   a_next_wake_same: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> (rsp_next_wake == $past(rsp_next_wake)))
      else $error("next wake changed within a step");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == ssqt_pkg::KIND_WOKEN || rsp_kind == ssqt_pkg::KIND_ACCEPT ||
                     rsp_kind == ssqt_pkg::KIND_REJECT))
      else $error("undefined result kind");

endmodule

bind sorted_sleep_queue_timer ssqt_checker u_ssqt_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_kind      (rsp_kind),
   .rsp_next_wake (rsp_next_wake),
   .rsp_last      (rsp_last)
);
